// ----- sv/cig_pkg.sv -----
package cig_pkg;

    localparam int GRID_RES   = 64;
    localparam int IDX_W      = $clog2(GRID_RES);
    localparam int ADDR_W     = 2 * IDX_W;
    localparam int H_W        = 16;
    localparam int OFF_W      = 24;
    localparam int INT_W      = 16;
    localparam int MUL_W      = 18;
    localparam int DEN_W      = 64;
    localparam int DIV_W      = 40;
    localparam int NUM_H      = 9;
    localparam int NUM_OFF    = 6;
    localparam int CHUNK_W    = 17;

    localparam logic signed [H_W-1:0] DEPTH_RESET = 16'sd4096;
    localparam logic signed [INT_W-1:0] INT_ONE   = 16'sd16384;
    localparam logic signed [INT_W-1:0] INT_LOW   = -16'sd2048;
    localparam logic [DIV_W-1:0] INT_EIGHTH       = 40'd2048;
    localparam logic [DIV_W-1:0] QUO_CLAMP        = 40'd18432;

    localparam logic [2:0] REG_LIGHT_DEPTH = 3'd0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_OMUL,
        ST_ORND,
        ST_SPAC,
        ST_DMUL,
        ST_DACC,
        ST_CHK,
        ST_DIV,
        ST_FIN,
        ST_DONE
    } t_state;

endpackage

// ----- sv/caustic_intensity_grid_core.sv -----
// Caustic intensity grid: holds a 64 x 64 toroidal grid of Q4.12 water heights
// and answers queries with the projected light offsets (Q12.12, saturated)
// and caustic intensity (Q1.14, clamped at 1.0) of one grid point. A write
// request (tuser = 0) stores a height when it is accepted. A query request
// (tuser = 1) keeps the input side busy from its acceptance until its result
// is loaded: height reads through the single read port of the height memory
// (nine heights), six offsets through one shared 18 x 18 multiplier (multiply
// then round), the spacing sums, four partial products of the spacing product
// on the same multiplier, a check, a 40-step restoring division, a rounding
// step and the load of the result register. When the spacing product is zero
// or too large to give a nonzero quotient the division is skipped. A result
// that waits in the output register holds the block in its last state for as
// long as the stall lasts. Heights must be written before a query touches
// them; the memory is not cleared.
module caustic_intensity_grid_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // row[5:0], col[11:6], height[27:12], zero pad
    input  logic        s_axis_tuser,   // func: 0 write height, 1 query
    // stream out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // point_row[5:0], point_col[11:6],
                                        // x_offset[35:12], z_offset[59:36],
                                        // intensity[75:60], zero pad
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import cig_pkg::*;

    t_state r_state, n_state;

    logic signed [H_W-1:0]   r_depth;
    logic [H_W-1:0]          mem [GRID_RES*GRID_RES];
    logic signed [H_W-1:0]   r_rdata;
    logic [IDX_W-1:0]        r_row, r_col;
    logic signed [H_W-1:0]   r_h [NUM_H];
    logic signed [OFF_W-1:0] r_off [NUM_OFF];
    logic [5:0]              r_cnt;
    logic signed [2*MUL_W-1:0] r_prod;
    logic [31:0]             r_p, r_q;
    logic [DEN_W-1:0]        r_den;
    logic [DIV_W:0]          r_rem;
    logic [DIV_W-1:0]        r_quo;
    logic signed [INT_W-1:0] r_inten;
    logic                    r_ovalid;
    logic [79:0]             r_odata;

    logic                    in_acc, out_free;
    logic [IDX_W-1:0]        in_row, in_col, rd_row, rd_col;
    logic [ADDR_W-1:0]       rd_addr;
    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic signed [2*MUL_W-1:0] prod;
    logic signed [H_W:0]     d_ha, d_hb, d_hs;
    logic signed [41:0]      rnd_t;
    logic signed [28:0]      rnd_v;
    logic signed [OFF_W-1:0] off_sat;
    logic [31:0]             p_sum, q_sum;
    logic [DIV_W:0]          rem_sh;
    logic [DIV_W-1:0]        quo_r;

    assign in_row   = s_axis_tdata[IDX_W-1:0];
    assign in_col   = s_axis_tdata[2*IDX_W-1:IDX_W];
    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_ovalid || m_axis_tready;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign pready   = 1'b1;
    assign prdata   = (paddr == REG_LIGHT_DEPTH) ? 32'(r_depth) : 32'd0;

    // neighbour address for each height slot
    always_comb begin
        rd_row = r_row;
        rd_col = r_col;
        case (r_cnt[3:0])
            4'd1: rd_row = r_row + IDX_W'(1);
            4'd2: rd_row = r_row - IDX_W'(1);
            4'd3: rd_row = r_row + IDX_W'(2);
            4'd4: rd_row = r_row - IDX_W'(2);
            4'd5: rd_col = r_col + IDX_W'(1);
            4'd6: rd_col = r_col - IDX_W'(1);
            4'd7: rd_col = r_col + IDX_W'(2);
            4'd8: rd_col = r_col - IDX_W'(2);
            default: ;
        endcase
        rd_addr = {rd_row, rd_col};
    end

    // shared multiplier operands
    always_comb begin
        d_ha = 17'(r_h[1]);
        d_hb = 17'(r_h[2]);
        d_hs = 17'(r_h[0]);
        case (r_cnt[2:0])
            3'd1: begin d_ha = 17'(r_h[5]); d_hb = 17'(r_h[6]); d_hs = 17'(r_h[0]); end
            3'd2: begin d_ha = 17'(r_h[3]); d_hb = 17'(r_h[0]); d_hs = 17'(r_h[1]); end
            3'd3: begin d_ha = 17'(r_h[0]); d_hb = 17'(r_h[4]); d_hs = 17'(r_h[2]); end
            3'd4: begin d_ha = 17'(r_h[7]); d_hb = 17'(r_h[0]); d_hs = 17'(r_h[5]); end
            3'd5: begin d_ha = 17'(r_h[0]); d_hb = 17'(r_h[8]); d_hs = 17'(r_h[6]); end
            default: ;
        endcase
        if (r_state == ST_DMUL) begin
            mul_a = r_cnt[1] ? MUL_W'(r_p[31:CHUNK_W]) : MUL_W'(r_p[CHUNK_W-1:0]);
            mul_b = r_cnt[0] ? MUL_W'(r_q[31:CHUNK_W]) : MUL_W'(r_q[CHUNK_W-1:0]);
        end else begin
            mul_a = MUL_W'(d_ha - d_hb);
            mul_b = MUL_W'(17'(r_depth) + d_hs);
        end
        prod = mul_a * mul_b;
    end

    // round half up after scaling by the grid size, then saturate
    always_comb begin
        rnd_t = (42'(r_prod) <<< IDX_W) + 42'sd4096;
        rnd_v = 29'(rnd_t >>> 13);
        if (rnd_v > 29'sd8388607)
            off_sat = 24'sh7FFFFF;
        else if (rnd_v < -29'sd8388608)
            off_sat = 24'sh800000;
        else
            off_sat = rnd_v[OFF_W-1:0];
    end

    function automatic logic [31:0] spacing(input logic signed [OFF_W-1:0] a,
                                            input logic signed [OFF_W-1:0] b);
        logic signed [31:0] t;
        t = ((32'(a) - 32'(b)) <<< IDX_W) + 32'sd4096;
        return t[31] ? 32'(-t) : 32'(t);
    endfunction

    assign p_sum  = spacing(r_off[2], r_off[0]) + spacing(r_off[0], r_off[3]);
    assign q_sum  = spacing(r_off[4], r_off[1]) + spacing(r_off[1], r_off[5]);
    assign rem_sh = {r_rem[DIV_W-1:0], (r_cnt == 6'd0)};
    assign quo_r  = DIV_W'(({1'b0, r_quo} + 41'd1) >> 1);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (in_acc && s_axis_tuser) n_state = ST_READ;
            ST_READ: if (r_cnt == 6'd9) n_state = ST_OMUL;
            ST_OMUL: n_state = ST_ORND;
            ST_ORND: n_state = (r_cnt == 6'(NUM_OFF-1)) ? ST_SPAC : ST_OMUL;
            ST_SPAC: n_state = ST_DMUL;
            ST_DMUL: n_state = ST_DACC;
            ST_DACC: n_state = (r_cnt == 6'd3) ? ST_CHK : ST_DMUL;
            ST_CHK: begin
                if (r_p == 32'd0 || r_q == 32'd0 || r_den[DEN_W-1:DIV_W] != '0)
                    n_state = ST_DONE;
                else
                    n_state = ST_DIV;
            end
            ST_DIV:  if (r_cnt == 6'(DIV_W-1)) n_state = ST_FIN;
            ST_FIN:  n_state = ST_DONE;
            ST_DONE: if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    // height memory: write on request, one registered read
    always_ff @(posedge i_clk) begin
        if (in_acc && !s_axis_tuser)
            mem[{in_row, in_col}] <= s_axis_tdata[2*IDX_W+H_W-1:2*IDX_W];
        r_rdata <= mem[rd_addr];
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_depth <= DEPTH_RESET;
        else if (psel && penable && pwrite && pready && paddr == REG_LIGHT_DEPTH)
            r_depth <= pwdata[H_W-1:0];
    end

    // datapath sequencing
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_cnt <= '0;
                if (in_acc) begin
                    r_row <= in_row;
                    r_col <= in_col;
                end
            end
            ST_READ: begin
                if (r_cnt != 6'd0) r_h[r_cnt[3:0] - 4'd1] <= r_rdata;
                r_cnt <= (r_cnt == 6'd9) ? 6'd0 : r_cnt + 6'd1;
            end
            ST_OMUL: r_prod <= prod;
            ST_ORND: begin
                r_off[r_cnt[2:0]] <= off_sat;
                r_cnt <= (r_cnt == 6'(NUM_OFF-1)) ? 6'd0 : r_cnt + 6'd1;
            end
            ST_SPAC: begin
                r_p   <= p_sum;
                r_q   <= q_sum;
                r_den <= '0;
            end
            ST_DMUL: r_prod <= prod;
            ST_DACC: begin
                r_den <= r_den + (DEN_W'(r_prod) << (CHUNK_W * (32'(r_cnt[1]) + 32'(r_cnt[0]))));
                r_cnt <= (r_cnt == 6'd3) ? 6'd0 : r_cnt + 6'd1;
            end
            ST_CHK: begin
                r_rem <= '0;
                r_quo <= '0;
                if (r_p == 32'd0 || r_q == 32'd0) r_inten <= INT_ONE;
                else                              r_inten <= INT_LOW;
            end
            ST_DIV: begin
                // one quotient bit of 2^39 / den per cycle
                if (rem_sh >= {1'b0, r_den[DIV_W-1:0]}) begin
                    r_rem <= rem_sh - {1'b0, r_den[DIV_W-1:0]};
                    r_quo <= {r_quo[DIV_W-2:0], 1'b1};
                end else begin
                    r_rem <= rem_sh;
                    r_quo <= {r_quo[DIV_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 6'd1;
            end
            ST_FIN: begin
                if (quo_r > QUO_CLAMP) r_inten <= INT_ONE;
                else                   r_inten <= INT_W'(quo_r - INT_EIGHTH);
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == ST_DONE && out_free) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && out_free)
            r_odata <= {4'd0, r_inten, r_off[1], r_off[0], r_col, r_row};
    end

endmodule

// ----- sv/cig_checker.sv -----
module cig_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [79:0] m_axis_tdata,
    input logic        pready
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped while stalled");

    a_int_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[75:60]) <= 16'sd16384 &&
                           $signed(m_axis_tdata[75:60]) >= -16'sd2048))
        else $error("intensity out of range");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready)
        else $error("query did not hold off input");

    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !s_axis_tuser && !m_axis_tvalid
        |=> !m_axis_tvalid)
        else $error("write produced a result");

    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready low");
endmodule

bind caustic_intensity_grid_core cig_checker u_cig_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .pready        (pready)
);
